### hdl/mrlp_pkg.sv
// Shared types and constants for the modem response line parser.
// No dependencies; every other file in hdl imports this package.
`default_nettype none

package mrlp_pkg;

    localparam int LINE_KEEP_DEF = 24;
    // Highest line position that any field is taken from is 21.
    localparam int HEAD_READ = 22;
    localparam int LEN_W = 8;
    localparam int IDENT_CHARS = 15;
    localparam int IDENT_FIRST = 7;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_PROMPT = 8'h3E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_FIVE   = 8'h35;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic [63:0] PFX_MODEM = "MODEM:ST";
    localparam logic [15:0] PFX_OK    = "OK";
    localparam logic [39:0] PFX_ERROR = "ERROR";
    localparam logic [31:0] PFX_CSQ   = "+CSQ";
    localparam logic [39:0] PFX_CREG  = "+CREG";
    localparam logic [47:0] PFX_CGSN  = "+CGSN:";
    localparam logic [47:0] PFX_XIIC  = "+XIIC:";

    localparam logic [6:0] SQ_INVALID = 7'd99;

    typedef enum logic [2:0] {
        EV_PROMPT       = 3'd0,
        EV_MODEM_START  = 3'd1,
        EV_OK           = 3'd2,
        EV_ERROR        = 3'd3,
        EV_SIGNAL       = 3'd4,
        EV_REGISTRATION = 3'd5,
        EV_IDENTITY     = 3'd6,
        EV_LINK         = 3'd7
    } event_kind_t;

    // What the line store decided about the byte it just took.
    typedef struct packed {
        logic             prompt_hit;
        logic             line_end;
        logic [LEN_W-1:0] len;
    } line_ev_t;

    typedef struct packed {
        event_kind_t kind;
        logic [6:0]  signal_quality;
        logic [2:0]  registration;
        logic        link_up;
        logic [59:0] identity_digits;
    } result_t;

endpackage

`default_nettype wire

### hdl/modem_response_line_parser.sv
// Modem reply line parser: one received byte per word in, at most one event word out.
// A byte first lands in an input register; once the output side can take a result it updates
// the line state and, on one of the first two '>' prompts or on an LF after a CR that ends a
// recognised line, a result is registered at the output. A byte is taken every cycle while the
// output side keeps up; the stall on the input follows the output stall only when the
// result register is full. Bytes past LINE_KEEP are counted but not stored.
// Depends on mrlp_pkg, mrlp_line_store and mrlp_classify.
`default_nettype none

module modem_response_line_parser #(
    parameter int LINE_KEEP = mrlp_pkg::LINE_KEEP_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       event_kind,
    output logic [6:0]       signal_quality,
    output logic [2:0]       registration,
    output logic             link_up,
    output logic [59:0]      identity_digits
);
    import mrlp_pkg::*;

    logic                       byte_valid_reg;
    logic                       byte_valid_next;
    logic [7:0]                 byte_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    result_t                    result_reg;
    result_t                    result_next;
    logic                       advance;
    logic                       step;
    logic                       take_in;
    logic                       cls_match;
    logic                       emit;
    line_ev_t                   ev;
    result_t                    cls_res;
    logic [HEAD_READ-1:0][7:0]  head;

    assign advance  = !out_valid_reg || !out_stall;
    assign step     = byte_valid_reg && advance;
    assign in_stall = byte_valid_reg && !advance;
    assign take_in  = in_valid && !in_stall;

    mrlp_line_store #(
        .LINE_KEEP (LINE_KEEP)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (byte_reg),
        .ev      (ev),
        .head    (head)
    );

    mrlp_classify u_classify (
        .len   (ev.len),
        .head  (head),
        .match (cls_match),
        .res   (cls_res)
    );

    assign emit = ev.prompt_hit || (ev.line_end && cls_match);

    always_comb
    begin
        byte_valid_next = take_in ? 1'b1 : (step ? 1'b0 : byte_valid_reg);
        out_valid_next  = advance ? (step && emit) : out_valid_reg;
        if (ev.prompt_hit)
        begin
            result_next      = '0;
            result_next.kind = EV_PROMPT;
        end
        else
        begin
            result_next = cls_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            byte_valid_reg <= byte_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            byte_reg <= rx_byte;
        end
        if (step && emit)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign event_kind      = result_reg.kind;
    assign signal_quality  = result_reg.signal_quality;
    assign registration    = result_reg.registration;
    assign link_up         = result_reg.link_up;
    assign identity_digits = result_reg.identity_digits;

endmodule

`default_nettype wire

### hdl/mrlp_line_store.sv
// Line buffer, line length, CR flag and prompt counter of the line parser.
// Depends on mrlp_pkg.
`default_nettype none

module mrlp_line_store #(
    parameter int LINE_KEEP = mrlp_pkg::LINE_KEEP_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                step,
    input  wire logic [7:0]                          rx_byte,
    output mrlp_pkg::line_ev_t                       ev,
    output logic [mrlp_pkg::HEAD_READ-1:0][7:0]      head
);
    import mrlp_pkg::*;

    localparam int IDX_W = $clog2(LINE_KEEP);

    logic [7:0]       head_mem [LINE_KEEP];
    logic [LEN_W-1:0] line_len_reg;
    logic [LEN_W-1:0] line_len_next;
    logic             cr_seen_reg;
    logic             cr_seen_next;
    logic [1:0]       prompt_cnt_reg;
    logic [1:0]       prompt_cnt_next;

    logic is_cr;
    logic is_prompt;
    logic line_end;
    logic prompt_hit;
    logic keep_byte;

    assign is_cr      = (rx_byte == CH_CR);
    assign is_prompt  = (rx_byte == CH_PROMPT);
    assign line_end   = (rx_byte == CH_LF) && cr_seen_reg;
    assign prompt_hit = is_prompt && (prompt_cnt_reg <= 2'd1);
    assign keep_byte  = !line_end;

    always_comb
    begin
        line_len_next   = line_len_reg;
        cr_seen_next    = cr_seen_reg;
        prompt_cnt_next = prompt_cnt_reg;
        if (step)
        begin
            // Only a CR leaves the flag set; a line end or any other byte clears it.
            cr_seen_next = is_cr;
            if (line_end)
            begin
                line_len_next = '0;
            end
            else if (line_len_reg != {LEN_W{1'b1}})
            begin
                line_len_next = line_len_reg + 1'b1;
            end
            if (prompt_hit)
            begin
                prompt_cnt_next = prompt_cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_len_reg   <= '0;
            cr_seen_reg    <= 1'b0;
            prompt_cnt_reg <= 2'd0;
        end
        else
        begin
            line_len_reg   <= line_len_next;
            cr_seen_reg    <= cr_seen_next;
            prompt_cnt_reg <= prompt_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && keep_byte && (line_len_reg < LEN_W'(LINE_KEEP)))
        begin
            head_mem[line_len_reg[IDX_W-1:0]] <= rx_byte;
        end
    end

    for (genvar i = 0; i < HEAD_READ; i++)
    begin : g_head
        assign head[i] = head_mem[i];
    end

    // The stored length counts the closing CR, which is not part of the line.
    assign ev.prompt_hit = prompt_hit;
    assign ev.line_end   = line_end;
    assign ev.len        = line_len_reg - 1'b1;

endmodule

`default_nettype wire

### hdl/mrlp_classify.sv
// Prefix classification and value extraction for one finished line.
// Depends on mrlp_pkg.
`default_nettype none

module mrlp_classify (
    input  wire logic [mrlp_pkg::LEN_W-1:0]          len,
    input  wire logic [mrlp_pkg::HEAD_READ-1:0][7:0] head,
    output logic                                     match,
    output mrlp_pkg::result_t                        res
);
    import mrlp_pkg::*;

    logic [7:0] c [HEAD_READ];
    logic       hit_modem;
    logic       hit_ok;
    logic       hit_error;
    logic       hit_csq;
    logic       hit_creg;
    logic       hit_cgsn;
    logic       hit_xiic;
    logic [7:0] sq_a;
    logic [7:0] sq_b;
    logic       sq_a_dig;
    logic       sq_b_dig;
    logic [6:0] sq_tens;
    logic [6:0] sq_val;
    logic [2:0] reg_val;
    logic       link_val;
    logic [59:0] ident_val;
    logic        ended;

    // Positions at or past the line end read as NUL.
    always_comb
    begin
        for (int i = 0; i < HEAD_READ; i++)
        begin
            c[i] = (LEN_W'(i) < len) ? head[i] : CH_NUL;
        end
    end

    assign hit_modem = (len >= LEN_W'(8)) &&
                       ({c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]} == PFX_MODEM);
    assign hit_ok    = (len >= LEN_W'(2)) && ({c[0], c[1]} == PFX_OK);
    assign hit_error = (len >= LEN_W'(5)) && ({c[0], c[1], c[2], c[3], c[4]} == PFX_ERROR);
    assign hit_csq   = (len >= LEN_W'(4)) && ({c[0], c[1], c[2], c[3]} == PFX_CSQ);
    assign hit_creg  = (len >= LEN_W'(5)) && ({c[0], c[1], c[2], c[3], c[4]} == PFX_CREG);
    assign hit_cgsn  = (len >= LEN_W'(6)) &&
                       ({c[0], c[1], c[2], c[3], c[4], c[5]} == PFX_CGSN);
    assign hit_xiic  = (len >= LEN_W'(6)) &&
                       ({c[0], c[1], c[2], c[3], c[4], c[5]} == PFX_XIIC);

    assign sq_a     = c[6];
    assign sq_b     = c[7];
    assign sq_a_dig = (sq_a >= CH_ZERO) && (sq_a <= CH_NINE);
    assign sq_b_dig = (sq_b >= CH_ZERO) && (sq_b <= CH_NINE);
    assign sq_tens  = {sq_a[3:0], 3'b000} + {2'b00, sq_a[3:0], 1'b0};

    always_comb
    begin
        priority if (sq_b == CH_COMMA)
        begin
            sq_val = sq_a_dig ? {3'b000, sq_a[3:0]} : SQ_INVALID;
        end
        else if (sq_a == CH_NINE)
        begin
            sq_val = 7'd0;
        end
        else if (sq_a_dig && sq_b_dig)
        begin
            sq_val = sq_tens + {3'b000, sq_b[3:0]};
        end
        else
        begin
            sq_val = SQ_INVALID;
        end
    end

    assign reg_val  = ((c[9] == CH_ONE) || (c[9] == CH_FIVE)) ? c[9][2:0] : 3'd0;
    assign link_val = (c[10] == CH_ONE) && (c[11] == CH_COMMA);

    // The first NUL ends the identity; every later nibble stays zero.
    always_comb
    begin
        ended     = 1'b0;
        ident_val = '0;
        for (int i = 0; i < IDENT_CHARS; i++)
        begin
            if (c[IDENT_FIRST + i] == CH_NUL)
            begin
                ended = 1'b1;
            end
            ident_val[59 - 4*i -: 4] = ended ? 4'h0 : c[IDENT_FIRST + i][3:0];
        end
    end

    always_comb
    begin
        res   = '0;
        match = (len > LEN_W'(1));
        priority if (hit_modem)
        begin
            res.kind = EV_MODEM_START;
        end
        else if (hit_ok)
        begin
            res.kind = EV_OK;
        end
        else if (hit_error)
        begin
            res.kind = EV_ERROR;
        end
        else if (hit_csq)
        begin
            res.kind           = EV_SIGNAL;
            res.signal_quality = sq_val;
        end
        else if (hit_creg)
        begin
            res.kind         = EV_REGISTRATION;
            res.registration = reg_val;
        end
        else if (hit_cgsn)
        begin
            res.kind            = EV_IDENTITY;
            res.identity_digits = ident_val;
        end
        else if (hit_xiic)
        begin
            res.kind    = EV_LINK;
            res.link_up = link_val;
        end
        else
        begin
            match = 1'b0;
        end
    end

endmodule

`default_nettype wire

### tb/tb_modem_response_line_parser.sv
// Self-checking bench for modem_response_line_parser: directed reply lines come first and
// random ones follow under stalls; a local parser predicts events not listed for a line.
// Depends on mrlp_pkg and the RTL in hdl.
module tb_modem_response_line_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import mrlp_pkg::*;

    localparam int KEEP = LINE_KEEP_DEF;
    localparam int RANDOM_BYTES = 350;
    localparam int MAX_REPORTS = 10;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [7:0] data;
        bit         typed;
        result_t    res;
    } tx_word_t;

    typedef struct {
        string   text;
        bit      typed;
        result_t res;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [2:0]  event_kind;
    logic [6:0]  signal_quality;
    logic [2:0]  registration;
    logic        link_up;
    logic [59:0] identity_digits;

    // Line state of the predictor.
    logic [7:0]  head_bytes [KEEP];
    int unsigned line_count = 0;
    bit          cr_pending = 1'b0;
    int unsigned prompts_seen = 0;

    result_t     pending_events [$];
    tx_word_t    tx_q [$];
    logic [7:0]  line_buf [$];
    dir_row_t    dir_rows [$];
    tx_word_t    cur_word;

    int unsigned words_taken = 0;
    int unsigned events_checked = 0;
    int unsigned mismatches = 0;
    int unsigned random_lines = 0;
    int unsigned press_point = 0;
    int unsigned kind_hits [8];

    modem_response_line_parser dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .event_kind      (event_kind),
        .signal_quality  (signal_quality),
        .registration    (registration),
        .link_up         (link_up),
        .identity_digits (identity_digits)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [7:0] line_char(int unsigned idx, int unsigned len);
        if (idx >= len || idx >= KEEP)
            return CH_NUL;
        return head_bytes[idx];
    endfunction

    // A prefix only counts when the line is at least as long as the prefix.
    function automatic bit head_has(string p, int unsigned len);
        if (len < p.len())
            return 1'b0;
        for (int i = 0; i < p.len(); i++)
            if (line_char(i, len) != p[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit classify_line(int unsigned len, output result_t r);
        logic [7:0]  a;
        logic [7:0]  c;
        logic [59:0] acc;
        bit          ended;
        r = '0;
        if (len <= 1)
            return 1'b0;
        if (head_has("MODEM:ST", len))
            r.kind = EV_MODEM_START;
        else if (head_has("OK", len))
            r.kind = EV_OK;
        else if (head_has("ERROR", len))
            r.kind = EV_ERROR;
        else if (head_has("+CSQ", len))
        begin
            a = line_char(6, len);
            c = line_char(7, len);
            r.kind = EV_SIGNAL;
            if (c == CH_COMMA)
                r.signal_quality = is_num(a) ? 7'(a - CH_ZERO) : SQ_INVALID;
            else if (a == CH_NINE)
                r.signal_quality = 7'd0;
            else if (is_num(a) && is_num(c))
                r.signal_quality = 7'((a - CH_ZERO) * 10 + (c - CH_ZERO));
            else
                r.signal_quality = SQ_INVALID;
        end
        else if (head_has("+CREG", len))
        begin
            c = line_char(9, len);
            r.kind = EV_REGISTRATION;
            r.registration = (c == CH_ONE || c == CH_FIVE) ? 3'(c - CH_ZERO) : 3'd0;
        end
        else if (head_has("+CGSN:", len))
        begin
            acc = '0;
            ended = 1'b0;
            r.kind = EV_IDENTITY;
            for (int i = 0; i < IDENT_CHARS; i++)
            begin
                a = line_char(IDENT_FIRST + i, len);
                if (a == CH_NUL)
                    ended = 1'b1;
                acc = {acc[55:0], ended ? 4'h0 : a[3:0]};
            end
            r.identity_digits = acc;
        end
        else if (head_has("+XIIC:", len))
        begin
            r.kind = EV_LINK;
            r.link_up = line_char(10, len) == CH_ONE && line_char(11, len) == CH_COMMA;
        end
        else
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic void store_byte(logic [7:0] b);
        if (line_count < KEEP)
            head_bytes[line_count] = b;
        if (line_count < 255)
            line_count++;
    endfunction

    function automatic bit parse_byte(logic [7:0] b, output result_t r);
        bit hit;
        hit = 1'b0;
        r = '0;
        if (b == CH_PROMPT)
        begin
            if (prompts_seen < 2)
            begin
                prompts_seen++;
                r.kind = EV_PROMPT;
                hit = 1'b1;
            end
            cr_pending = 1'b0;
            store_byte(b);
        end
        else if (b == CH_CR)
        begin
            cr_pending = 1'b1;
            store_byte(b);
        end
        else if (b == CH_LF && cr_pending)
        begin
            // The length seen by the classifier leaves out the closing CR.
            hit = classify_line(line_count - 1, r);
            line_count = 0;
            cr_pending = 1'b0;
        end
        else if (b == CH_LF)
            store_byte(b);
        else
        begin
            cr_pending = 1'b0;
            store_byte(b);
        end
        return hit;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endfunction

    function automatic void put_prefix(int unsigned sel);
        case (sel)
            0: put_text("MODEM:ST");
            1: put_text("OK");
            2: put_text("ERROR");
            3: put_text("+CSQ: ");
            4: put_text("+CREG: ");
            5: put_text("+CGSN: ");
            default: put_text("+XIIC:    ");
        endcase
    endfunction

    function automatic void flush_line(bit terminate, bit typed, result_t res);
        tx_word_t w;
        w.typed = 1'b0;
        w.res = '0;
        foreach (line_buf[i])
        begin
            w.data = line_buf[i];
            tx_q.push_back(w);
        end
        if (terminate)
        begin
            w.data = CH_CR;
            tx_q.push_back(w);
            w.data = CH_LF;
            w.typed = typed;
            w.res = res;
            tx_q.push_back(w);
        end
        line_buf.delete();
    endfunction

    function automatic void row(string text, bit typed, event_kind_t kind = EV_PROMPT,
                                int sq = 0, int regn = 0, bit link = 1'b0,
                                logic [59:0] ident = '0);
        dir_row_t d;
        d.text = text;
        d.typed = typed;
        d.res.kind = kind;
        d.res.signal_quality = 7'(sq);
        d.res.registration = 3'(regn);
        d.res.link_up = link;
        d.res.identity_digits = ident;
        dir_rows.push_back(d);
    endfunction

    function automatic logic [7:0] printable();
        return 8'($urandom_range(32, 126));
    endfunction

    // Mostly digits, with a comma, a NUL or another printable now and then.
    function automatic logic [7:0] rand_digit();
        case ($urandom_range(0, 19))
            0: return CH_NUL;
            1: return CH_COMMA;
            2: return printable();
            default: return 8'(CH_ZERO + $urandom_range(0, 9));
        endcase
    endfunction

    function automatic void random_line();
        int unsigned pick;
        int unsigned n;
        bit          terminate;
        pick = $urandom_range(0, 99);
        terminate = 1'b1;
        if (pick < 12)
        begin
            put_prefix($urandom_range(0, 2));
            repeat ($urandom_range(0, 6))
                line_buf.push_back(printable());
        end
        else if (pick < 30)
        begin
            put_prefix(3);
            line_buf.push_back(rand_digit());
            if ($urandom_range(0, 2) != 0)
                line_buf.push_back(rand_digit());
            put_text(",99");
        end
        else if (pick < 45)
        begin
            put_prefix(4);
            line_buf.push_back(rand_digit());
            line_buf.push_back(CH_COMMA);
            case ($urandom_range(0, 2))
                0: line_buf.push_back(CH_ONE);
                1: line_buf.push_back(CH_FIVE);
                default: line_buf.push_back(rand_digit());
            endcase
        end
        else if (pick < 60)
        begin
            put_prefix(5);
            repeat ($urandom_range(0, 20))
                line_buf.push_back(rand_digit());
        end
        else if (pick < 75)
        begin
            put_text("+XIIC:");
            repeat ($urandom_range(3, 5))
                put_text(" ");
            line_buf.push_back($urandom_range(0, 2) != 0 ? CH_ONE : rand_digit());
            line_buf.push_back($urandom_range(0, 3) != 0 ? CH_COMMA : rand_digit());
            put_text("10.0.0.1");
        end
        else if (pick < 85)
        begin
            repeat ($urandom_range(0, 12))
                line_buf.push_back(8'($urandom_range(0, 255)));
            terminate = 1'($urandom_range(0, 1));
        end
        else if (pick < 90)
        begin
            repeat ($urandom_range(0, 2))
                line_buf.push_back(printable());
        end
        else if (pick < 93)
        begin
            // Runs past the stored head and can run past the length saturation.
            put_prefix($urandom_range(0, 6));
            repeat ($urandom_range(230, 280))
                line_buf.push_back(rand_digit());
        end
        else
        begin
            put_text("OK");
            line_buf.push_back(CH_CR);
            repeat ($urandom_range(0, 4))
                line_buf.push_back(printable());
        end
        // Cut some well-formed lines short to hit the prefix length checks.
        if (pick < 75 && $urandom_range(0, 6) == 0)
        begin
            n = $urandom_range(0, line_buf.size());
            while (line_buf.size() > n)
                void'(line_buf.pop_back());
        end
        flush_line(terminate, 1'b0, '0);
        random_lines++;
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void log_mismatch(string field, logic [63:0] want, logic [63:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, field, want, got);
    endfunction

    always @(posedge clk)
    begin : scoreboard
        result_t want;
        result_t guess;
        bit      hit;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_events.size() == 0)
                    log_mismatch("unexpected event word, kind", '0, 64'(event_kind));
                else
                begin
                    want = pending_events.pop_front();
                    events_checked++;
                    kind_hits[want.kind]++;
                    if (event_kind != want.kind)
                        log_mismatch("event_kind", 64'(want.kind), 64'(event_kind));
                    if (signal_quality != want.signal_quality)
                        log_mismatch("signal_quality", 64'(want.signal_quality),
                                     64'(signal_quality));
                    if (registration != want.registration)
                        log_mismatch("registration", 64'(want.registration),
                                     64'(registration));
                    if (link_up != want.link_up)
                        log_mismatch("link_up", 64'(want.link_up), 64'(link_up));
                    if (identity_digits != want.identity_digits)
                        log_mismatch("identity_digits", 64'(want.identity_digits),
                                     64'(identity_digits));
                end
            end
            if (in_valid && !in_stall)
            begin
                words_taken++;
                hit = parse_byte(rx_byte, guess);
                if (cur_word.typed)
                    pending_events.push_back(cur_word.res);
                else if (hit)
                    pending_events.push_back(guess);
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    initial
    begin : out_stall_pattern
        int unsigned mode;
        int unsigned span;
        int unsigned phase;
        bit          pressed;
        pressed = 1'b0;
        phase = 0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 150);
            repeat (span)
            begin
                @(negedge clk);
                // One long hold-off while bytes keep coming, so the input backs up.
                if (!pressed && words_taken >= press_point)
                begin
                    pressed = 1'b1;
                    out_stall <= 1'b1;
                    repeat (HOLD_CYCLES)
                        @(negedge clk);
                end
                phase = (phase + 1) % 5;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= $urandom_range(0, 3) == 0;
                    2: out_stall <= $urandom_range(0, 3) != 0;
                    default: out_stall <= phase < 3;
                endcase
            end
        end
    end

    initial
    begin : watchdog
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

    // ---------------------------------------------------------------- main

    initial
    begin : main_flow
        tx_word_t    w;
        int unsigned burst_left;
        int unsigned gap;
        int unsigned base;
        string       long_err;

        long_err = "ERROR";
        repeat (260)
            long_err = {long_err, "9"};

        row(">", 1'b0);
        row("OK", 1'b1, EV_OK);
        row(">>", 1'b0);
        row("MODEM:ST", 1'b1, EV_MODEM_START);
        row("MODEM:S", 1'b0);
        row("ERROR", 1'b1, EV_ERROR);
        row("ERRO", 1'b0);
        row("O", 1'b0);
        row("", 1'b0);
        row("+CSQ: 23,99", 1'b1, EV_SIGNAL, 23);
        row("+CSQ: 5,99", 1'b1, EV_SIGNAL, 5);
        row("+CSQ: 99,99", 1'b1, EV_SIGNAL, 0);
        row("+CSQ: 2x,99", 1'b1, EV_SIGNAL, 99);
        row("+CSQ", 1'b1, EV_SIGNAL, 99);
        row("+CREG: 0,1", 1'b1, EV_REGISTRATION, 0, 1);
        row("+CREG: 0,5", 1'b1, EV_REGISTRATION, 0, 5);
        row("+CREG: 0,2", 1'b1, EV_REGISTRATION, 0, 0);
        row("+CGSN: 867530912345678", 1'b1, EV_IDENTITY, 0, 0, 1'b0, 60'h867530912345678);
        row("+CGSN: 123", 1'b1, EV_IDENTITY, 0, 0, 1'b0, 60'h123000000000000);
        row("+CGSN: 987654321098765432109876", 1'b1, EV_IDENTITY, 0, 0, 1'b0,
            60'h987654321098765);
        row("+XIIC:    1,10.0.0.1", 1'b1, EV_LINK, 0, 0, 1'b1);
        row("+XIIC:    0,0.0.0.0", 1'b1, EV_LINK, 0, 0, 1'b0);
        row("+XIIC:", 1'b1, EV_LINK, 0, 0, 1'b0);
        row("\x0AOK", 1'b0);
        row("OK\x0D\x0D", 1'b1, EV_OK);
        row("\xFF\x80\x7F", 1'b0);
        row(long_err, 1'b1, EV_ERROR);

        foreach (dir_rows[i])
        begin
            put_text(dir_rows[i].text);
            flush_line(1'b1, dir_rows[i].typed, dir_rows[i].res);
        end
        press_point = tx_q.size() + 150;

        base = tx_q.size();
        while (tx_q.size() - base < RANDOM_BYTES)
            random_line();

        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        burst_left = 0;
        while (tx_q.size() != 0)
        begin
            w = tx_q.pop_front();
            @(negedge clk);
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 48);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                if (gap != 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap)
                        @(negedge clk);
                end
            end
            burst_left--;
            cur_word = w;
            rx_byte <= w.data;
            in_valid <= 1'b1;
            do
                @(posedge clk);
            while (in_stall);
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);

        $display(
            "Sent %0d bytes, %0d directed and %0d random lines, %0d events, %0d mismatches.",
            words_taken, dir_rows.size(), random_lines, events_checked, mismatches);
        $display("Events by kind 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
                 kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3],
                 kind_hits[4], kind_hits[5], kind_hits[6], kind_hits[7]);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### files.f
hdl/mrlp_pkg.sv
hdl/mrlp_line_store.sv
hdl/mrlp_classify.sv
hdl/modem_response_line_parser.sv
tb/tb_modem_response_line_parser.sv
